### rtl/nmea_sentence_receiver_unit_defines.svh
// Assertion macros used by the receiver top level.
`ifndef NMEA_SENTENCE_RECEIVER_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_RECEIVER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define NSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NSR_ASSERT(lbl, prop, msg)
`define NSR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/nsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

  // Request codes carried in the req_type field.
  typedef enum logic [1:0] {
    REQ_RX      = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2
  } nsr_req_e;

  // Character constants used by the parser and the top level.
  localparam logic [7:0] START_CHAR_RESET = 8'h24;
  localparam logic [7:0] CHAR_STAR        = 8'h2A;
  localparam logic [7:0] CHAR_NINE        = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A     = 8'h41;
  localparam logic [7:0] CHAR_ZERO        = 8'h30;
  localparam logic [7:0] CHAR_CR          = 8'h0D;
  localparam logic [7:0] CHAR_LF          = 8'h0A;
  localparam logic [7:0] HEX_TEN          = 8'd10;

  // One request word.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [6:0] read_offset;
  } nsr_in_t;

  // One result word.
  typedef struct packed {
    logic [7:0] read_data;
    logic       sentence_available;
    logic       sentence_completed;
  } nsr_out_t;

  // Store write request from the parser.
  typedef struct packed {
    logic       we;
    logic       done;
    logic [7:0] data;
  } nsr_wr_t;

endpackage

`default_nettype wire

### rtl/nsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/nsr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module nsr_parser
  import nsr_pkg::*;
#(
  parameter int SLOT_BYTES = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rx_en_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [7:0]                    start_char_i,
  output nsr_wr_t                            wr_o,
  output logic      [$clog2(SLOT_BYTES)-1:0] wr_pos_o
);

  localparam int OFF_W = $clog2(SLOT_BYTES);
  localparam int POS_W = $clog2(SLOT_BYTES + 1);

  localparam logic [2:0] PS_HUNT = 3'd0;
  localparam logic [2:0] PS_DATA = 3'd1;
  localparam logic [2:0] PS_CK1  = 3'd2;
  localparam logic [2:0] PS_CK2  = 3'd3;
  localparam logic [2:0] PS_CR   = 3'd4;
  localparam logic [2:0] PS_LF   = 3'd5;

  logic [2:0]       state_q, state_d, state_mid;
  logic [POS_W-1:0] pos_q, pos_d, pos_base, pos_inc;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       nibble;
  logic             done;

  // Hex digit value of the incoming byte, uppercase only.
  always_comb begin
    if (rx_byte_i > CHAR_NINE) begin
      nibble = rx_byte_i - CHAR_UPPER_A + HEX_TEN;
    end else begin
      nibble = rx_byte_i - CHAR_ZERO;
    end
  end

  // Sentence state machine.
  always_comb begin
    state_mid = state_q;
    pos_base  = pos_q;
    xor_d     = xor_q;
    done      = 1'b0;
    unique case (state_q)
      PS_HUNT: begin
        if (rx_byte_i == start_char_i) begin
          state_mid = PS_DATA;
          pos_base  = '0;
          xor_d     = '0;
        end
      end
      PS_DATA: begin
        if (rx_byte_i != CHAR_STAR) begin
          xor_d = xor_q ^ rx_byte_i;
        end else begin
          state_mid = PS_CK1;
        end
      end
      PS_CK1: begin
        state_mid = (nibble == {4'h0, xor_q[7:4]}) ? PS_CK2 : PS_HUNT;
      end
      PS_CK2: begin
        state_mid = (nibble == {4'h0, xor_q[3:0]}) ? PS_CR : PS_HUNT;
      end
      PS_CR: begin
        state_mid = (rx_byte_i == CHAR_CR) ? PS_LF : PS_HUNT;
      end
      PS_LF: begin
        done      = (rx_byte_i == CHAR_LF);
        state_mid = PS_HUNT;
      end
      default: begin
        state_mid = PS_HUNT;
      end
    endcase

    // Every byte kept in a sentence but the closing LF advances the position; a full slot aborts.
    pos_inc = pos_base + 1'b1;
    state_d = state_mid;
    pos_d   = pos_base;
    if (state_mid != PS_HUNT) begin
      pos_d = pos_inc;
      if (pos_inc == POS_W'(SLOT_BYTES)) begin
        state_d = PS_HUNT;
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_HUNT;
      pos_q   <= '0;
      xor_q   <= '0;
    end else if (rx_en_i) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

  // Store write for the byte just taken; the closing LF equals the input byte.
  assign wr_o.we   = rx_en_i && ((state_mid != PS_HUNT) || done);
  assign wr_o.done = rx_en_i && done;
  assign wr_o.data = rx_byte_i;
  assign wr_pos_o  = pos_base[OFF_W-1:0];

endmodule

`default_nettype wire

### rtl/nmea_sentence_receiver_unit.sv
// NMEA sentence receiver.
// Request words arrive on the in channel (valid/ready): a received UART byte,
// a read of one byte of the oldest stored sentence, or a release of it.
// Each request word yields exactly one result word on the out channel
// (valid/ready): read data, the sentence-available flag and a flag marking
// the LF that completed a sentence with a good checksum.
// A valid result appears in the cycle after acceptance; the block takes one
// word per cycle while the out channel is not stalled; the sentence store has a
// registered read port. A new word is accepted while the output register is empty or
// being taken in the same cycle.
// When the receiver stalls, the result holds and the in channel stops. The start
// character must be written through cfg_we_i / cfg_wdata_i only while idle; the
// block does not enforce this. Reset returns the parser to hunting, empties the
// ring of slots and sets the start character to the dollar sign; the store
// contents are left as they are and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_sentence_receiver_unit_defines.svh"

module nmea_sentence_receiver_unit
  import nsr_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  parameter int SLOT_BYTES = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire nsr_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output nsr_out_t        out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int OFF_W  = $clog2(SLOT_BYTES);
  localparam int OFFX_W = (OFF_W > 7) ? OFF_W : 7;
  localparam int DEPTH  = SLOT_COUNT * (1 << OFF_W);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        start_char_q;
  logic [SLOT_W-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
  logic              out_valid_q, avail_q, done_q, rd_flag_q;
  logic              accept, rx_en, rd_en, rel_en, ring_nonempty, off_ok;
  logic [OFFX_W-1:0] off_x;
  logic [OFF_W-1:0]  wr_pos;
  logic [7:0]        rdata;
  nsr_wr_t           wr;

  // Input handshake.
  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign ring_nonempty = (wslot_q != rslot_q);
  assign off_x         = OFFX_W'(in_data_i.read_offset);
  assign off_ok        = ({1'b0, off_x} < (OFFX_W + 1)'(SLOT_BYTES));

  // Request decode.
  always_comb begin
    rx_en  = 1'b0;
    rd_en  = 1'b0;
    rel_en = 1'b0;
    if (accept) begin
      case (in_data_i.req_type)
        REQ_RX:      rx_en  = 1'b1;
        REQ_READ:    rd_en  = ring_nonempty && off_ok;
        REQ_RELEASE: rel_en = ring_nonempty;
        default:     ;
      endcase
    end
  end

  // Start character register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= START_CHAR_RESET;
    end else if (cfg_we_i) begin
      start_char_q <= cfg_wdata_i;
    end
  end

  nsr_parser #(
    .SLOT_BYTES(SLOT_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_en_i     (rx_en),
    .rx_byte_i   (in_data_i.rx_byte),
    .start_char_i(start_char_q),
    .wr_o        (wr),
    .wr_pos_o    (wr_pos)
  );

  nsr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr.we),
    .waddr_i(ADDR_W'({wslot_q, wr_pos})),
    .wdata_i(wr.data),
    .re_i   (rd_en),
    .raddr_i(ADDR_W'({rslot_q, off_x[OFF_W-1:0]})),
    .rdata_o(rdata)
  );

  // Ring pointers: head moves on a completed sentence, tail on a release.
  always_comb begin
    wslot_d = wslot_q;
    rslot_d = rslot_q;
    if (wr.done) begin
      wslot_d = (wslot_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : wslot_q + 1'b1;
    end
    if (rel_en) begin
      rslot_d = (rslot_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rslot_q + 1'b1;
    end
  end

  // Pointers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q     <= '0;
      rslot_q     <= '0;
      out_valid_q <= 1'b0;
      avail_q     <= 1'b0;
      done_q      <= 1'b0;
      rd_flag_q   <= 1'b0;
    end else begin
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        avail_q     <= (wslot_d != rslot_d);
        done_q      <= wr.done;
        rd_flag_q   <= rd_en;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o                   = out_valid_q;
  assign out_data_o.read_data          = rd_flag_q ? rdata : 8'h00;
  assign out_data_o.sentence_available = avail_q;
  assign out_data_o.sentence_completed = done_q;

  // Checks on the ring and the output stage.
  `NSR_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid right after reset")
  `NSR_ASSERT(a_no_rw_clash, !(wr.we && rd_en), "store written and read by one word")
  `NSR_ASSERT(a_done_moves_head, wr.done |=> wslot_q != $past(wslot_q), "head did not move")
  `NSR_ASSERT(a_done_no_data, out_valid_o && out_data_o.sentence_completed |-> out_data_o.read_data == 8'h00, "read data with completion")

endmodule

`default_nettype wire
